>>> sv/hss_pkg.sv
// Shared types, constants and lookup functions for the hall six-step commutation block.
`default_nettype none

package hss_pkg;

   localparam int POT_BITS_DEFAULT = 12;
   localparam int VAL_W            = 14;   // period, top, compare width
   localparam int SECTOR_W         = 3;
   localparam int COUNT_W          = 8;
   localparam int DEAD_W           = 10;
   localparam int GAIN_W           = 16;
   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int RSP_DATA_W       = 88;
   localparam int RSP_USER_W       = 2;

   localparam logic [VAL_W-1:0]    PERIOD_RESET   = 14'd10000;
   localparam logic [VAL_W-1:0]    PERIOD_SLOW    = 14'd10000;
   localparam logic [15:0]         POT_LOW_LIMIT  = 16'd800;
   localparam logic [15:0]         POT_HIGH_LIMIT = 16'd3000;
   localparam logic [15:0]         PERIOD_BASE    = 16'd9200;
   localparam logic [DEAD_W-1:0]   DEAD_RESET     = 10'd160;
   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd19661;
   localparam logic [COUNT_W-1:0]  ENTER_RESET    = 8'd10;
   localparam logic [COUNT_W-1:0]  LEAVE_RESET    = 8'd14;
   localparam logic [COUNT_W-1:0]  TICK_RESET     = 8'd100;
   localparam logic [COUNT_W-1:0]  TICK_SIX_STEP  = 8'd100;
   localparam logic [COUNT_W-1:0]  TICK_WRAP      = 8'd200;
   localparam logic [SECTOR_W-1:0] SECTOR_INVALID = 3'd6;

   typedef enum logic [1:0] {
      OP_HALL    = 2'd0,
      OP_TICK    = 2'd1,
      OP_CAPTURE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEAD_TIME   = 2'd0,
      CSR_DRIVE_GAIN  = 2'd1,
      CSR_ENTER_SINE  = 2'd2,
      CSR_LEAVE_SINE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL1,
      ST_MUL2,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_HALF  = 2'd0,
      PH_PLUS  = 2'd1,
      PH_MINUS = 2'd2
   } phase_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic mul1;
      logic mul2;
      logic compare;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_compare;
   } dp_status_type;

   // Hall code is u + 2*w + 4*v.
   function automatic logic [SECTOR_W-1:0] sector_of(input logic [2:0] code);
      logic [SECTOR_W-1:0] s;
      unique case (code)
         3'd1:    s = 3'd4;
         3'd2:    s = 3'd2;
         3'd3:    s = 3'd3;
         3'd4:    s = 3'd0;
         3'd5:    s = 3'd5;
         3'd6:    s = 3'd1;
         default: s = SECTOR_INVALID;
      endcase
      return s;
   endfunction

   function automatic phase_type phase_of(input logic [SECTOR_W-1:0] sector,
                                          input logic [1:0] k);
      phase_type p;
      unique case ({sector, k})
         {3'd0, 2'd0}: p = PH_PLUS;
         {3'd0, 2'd1}: p = PH_MINUS;
         {3'd1, 2'd0}: p = PH_PLUS;
         {3'd1, 2'd2}: p = PH_MINUS;
         {3'd2, 2'd1}: p = PH_PLUS;
         {3'd2, 2'd2}: p = PH_MINUS;
         {3'd3, 2'd0}: p = PH_MINUS;
         {3'd3, 2'd1}: p = PH_PLUS;
         {3'd4, 2'd0}: p = PH_MINUS;
         {3'd4, 2'd2}: p = PH_PLUS;
         {3'd5, 2'd1}: p = PH_MINUS;
         {3'd5, 2'd2}: p = PH_PLUS;
         default:      p = PH_HALF;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> sv/hss_ctrl.sv
// Sequencer for the commutation block: update, multiply and compare if needed, then output.
`default_nettype none

module hss_ctrl
   import hss_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_compare ? ST_MUL1 : ST_DONE;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/hss_dp.sv
// Datapath: motor state, settings, carrier and compare arithmetic, result register.
`default_nettype none

module hss_dp
   import hss_pkg::*;
#(
   parameter int POT_BITS = POT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            item_op,
   input  wire logic                  item_hall_u,
   input  wire logic                  item_hall_v,
   input  wire logic                  item_hall_w,
   input  wire logic [POT_BITS-1:0]   item_pot,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   output logic [RSP_DATA_W-1:0]      rsp_data,
   output logic [RSP_USER_W-1:0]      rsp_user
);

   localparam int P1_W = POT_BITS + VAL_W;
   localparam int P2_W = P1_W + GAIN_W;

   // settings
   logic [DEAD_W-1:0]  dead_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [COUNT_W-1:0] enter_ff;
   logic [COUNT_W-1:0] leave_ff;

   // latched item
   op_type              op_ff;
   logic [2:0]          code_ff;
   logic [POT_BITS-1:0] pot_ff;

   // motor state
   logic [VAL_W-1:0]    period_ff, period_in;
   logic [VAL_W-1:0]    top_ff, top_in;
   logic [VAL_W-1:0]    cmp_ff [3];
   logic [VAL_W-1:0]    cmp_in [3];
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [COUNT_W-1:0]  tick_ff, tick_in;
   logic [COUNT_W-1:0]  capture_ff, capture_in;
   logic                sine_ff, sine_in;
   logic                drv_ff, drv_in;
   logic                cmpu_ff, cmpu_in;

   logic [P1_W-1:0]     prod1_ff;
   logic [P2_W-1:0]     prod2_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [15:0]         pot_ext;
   logic [SECTOR_W-1:0] hall_sector;
   logic [VAL_W-1:0]    period_new;
   logic [COUNT_W-1:0]  tick_inc;
   logic [VAL_W-1:0]    delta;
   logic [VAL_W-1:0]    half;
   logic [VAL_W:0]      sum;
   logic [VAL_W-1:0]    plus_val;
   logic [VAL_W-1:0]    minus_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff  <= DEAD_RESET;
         gain_ff  <= GAIN_RESET;
         enter_ff <= ENTER_RESET;
         leave_ff <= LEAVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DEAD_TIME:  dead_ff  <= csr_wdata[DEAD_W-1:0];
            CSR_DRIVE_GAIN: gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_ENTER_SINE: enter_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LEAVE_SINE: leave_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(item_op);
         code_ff <= {item_hall_v, item_hall_w, item_hall_u};
         pot_ff  <= item_pot;
      end
      if (cmd.mul1)
         prod1_ff <= P1_W'(pot_ff) * P1_W'(top_ff);
      if (cmd.mul2)
         prod2_ff <= P2_W'(prod1_ff) * P2_W'(gain_ff);
      if (cmd.load_out) begin
         rsp_data_ff <= {6'd0, capture_ff, sine_ff, sector_ff,
                         cmp_ff[2], cmp_ff[1], cmp_ff[0], top_ff, period_ff};
         rsp_user_ff <= {cmpu_ff, drv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         top_ff     <= '0;
         cmp_ff     <= '{default: '0};
         sector_ff  <= '0;
         tick_ff    <= TICK_RESET;
         capture_ff <= '0;
         sine_ff    <= 1'b0;
         drv_ff     <= 1'b0;
         cmpu_ff    <= 1'b0;
      end else begin
         period_ff  <= period_in;
         top_ff     <= top_in;
         cmp_ff     <= cmp_in;
         sector_ff  <= sector_in;
         tick_ff    <= tick_in;
         capture_ff <= capture_in;
         sine_ff    <= sine_in;
         drv_ff     <= drv_in;
         cmpu_ff    <= cmpu_in;
      end
   end

   assign pot_ext     = 16'(pot_ff);
   assign hall_sector = sector_of(code_ff);
   assign tick_inc    = tick_ff + 8'd1;

   always_comb begin
      if (pot_ext < POT_LOW_LIMIT)
         period_new = PERIOD_SLOW;
      else if (pot_ext < POT_HIGH_LIMIT)
         period_new = VAL_W'(PERIOD_BASE + pot_ext);
      else
         period_new = period_ff;
   end

   assign status.need_compare = (op_ff == OP_HALL) && !sine_ff
                                && (hall_sector != SECTOR_INVALID);

   // delta = pot * top * gain >> (POT_BITS + 16)
   assign delta     = prod2_ff[P2_W-1 -: VAL_W];
   assign half      = {1'b0, top_ff[VAL_W-1:1]};
   assign sum       = {1'b0, half} + {1'b0, delta};
   assign plus_val  = (sum > {1'b0, top_ff}) ? top_ff : sum[VAL_W-1:0];
   assign minus_val = (delta > half) ? '0 : half - delta;

   always_comb begin
      period_in  = period_ff;
      top_in     = top_ff;
      cmp_in     = cmp_ff;
      sector_in  = sector_ff;
      tick_in    = tick_ff;
      capture_in = capture_ff;
      sine_in    = sine_ff;
      drv_in     = drv_ff;
      cmpu_in    = cmpu_ff;

      if (cmd.exec) begin
         drv_in  = 1'b0;
         cmpu_in = 1'b0;
         case (op_ff)
            OP_HALL: begin
               sector_in = hall_sector;
               if (!sine_ff) begin
                  period_in = period_new;
                  top_in    = VAL_W'({1'b0, period_new} + (VAL_W + 1)'(dead_ff));
                  drv_in    = 1'b1;
               end
            end
            OP_TICK: begin
               if (tick_inc >= TICK_SIX_STEP)
                  sine_in = 1'b0;
               tick_in = (tick_inc >= TICK_WRAP) ? TICK_SIX_STEP : tick_inc;
            end
            OP_CAPTURE: begin
               capture_in = tick_ff;
               tick_in    = '0;
               // leaving wins when both thresholds hold
               if (tick_ff >= leave_ff)
                  sine_in = 1'b0;
               else if (tick_ff <= enter_ff)
                  sine_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (cmd.compare) begin
         cmpu_in = 1'b1;
         for (int k = 0; k < 3; k++) begin
            case (phase_of(sector_ff, 2'(k)))
               PH_PLUS:  cmp_in[k] = plus_val;
               PH_MINUS: cmp_in[k] = minus_val;
               default:  cmp_in[k] = half;
            endcase
         end
      end
   end

   assign rsp_data = rsp_data_ff;
   assign rsp_user = rsp_user_ff;

endmodule

`default_nettype wire

>>> sv/hall_six_step_commutation.sv
// Hall six-step commutation: top level joining the sequencer and the datapath.
// Steps: a six-step hall edge with a valid code passes update, two registered multiplies,
// compare and output load after the transfer in; other items pass update and output load.
// Throughput: one item at a time; the next transfer in is taken once the sequencer is back
// in idle, after the last result is loaded, which waits while a stalled result is held.
// Reset: synchronous; state and settings return to their reset values, no result pending.
`default_nettype none

module hall_six_step_commutation
   import hss_pkg::*;
#(
   parameter int POT_BITS = POT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: hall_u, hall_v, hall_w, pot_level (lowest bit first), zero filled
   input  wire logic [((3 + POT_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,   // cmd
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: carrier_period, carrier_top, compare_u, compare_v, compare_w,
   //        sector_out, sine_mode_out, captured_count (lowest bit first), zero filled
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // drive_update, compare_update
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   hss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hss_dp #(
      .POT_BITS (POT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .item_op     (req_tuser),
      .item_hall_u (req_tdata[0]),
      .item_hall_v (req_tdata[1]),
      .item_hall_w (req_tdata[2]),
      .item_pot    (req_tdata[3 +: POT_BITS]),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_tdata),
      .rsp_user    (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> sv/hss_chk.sv
// Port checker for the commutation block, bound to the top level.
`default_nettype none

module hss_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_cmp_needs_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("compare update without carrier update");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tdata[41:28] <= rsp_tdata[27:14] && rsp_tdata[55:42] <= rsp_tdata[27:14]
         && rsp_tdata[69:56] <= rsp_tdata[27:14])
      else $error("compare above carrier top");

   a_sector_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[72:70] != 3'd7 && rsp_tdata[81:74] <= 8'd200)
      else $error("bad sector or captured count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind hall_six_step_commutation hss_chk u_hss_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/hss_commutation_checker.sv
// Checker for the hall commutation block: watches all ports, predicts and compares results.
module hss_commutation_checker
   import hss_pkg::*;
#(
   parameter int POT_BITS = POT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: hall_u, hall_v, hall_w, pot_level (lowest bit first), zero filled
   input  wire logic [((3 + POT_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,   // cmd
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // tdata: carrier_period, carrier_top, compare_u, compare_v, compare_w,
   //        sector_out, sine_mode_out, captured_count (lowest bit first), zero filled
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [RSP_USER_W-1:0] rsp_tuser,   // drive_update, compare_update
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W = ((3 + POT_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                drive_update;
      logic                compare_update;
      logic [VAL_W-1:0]    period;
      logic [VAL_W-1:0]    top;
      logic [VAL_W-1:0]    phase_u;
      logic [VAL_W-1:0]    phase_v;
      logic [VAL_W-1:0]    phase_w;
      logic [SECTOR_W-1:0] sector;
      logic                sine_mode;
      logic [COUNT_W-1:0]  captured;
   } commutation_type;

   commutation_type pending_commutations[$];
   int              mismatches = 0;

   // predicted block state and settings
   logic [DEAD_W-1:0]   dead_q;
   logic [GAIN_W-1:0]   gain_q;
   logic [COUNT_W-1:0]  enter_q;
   logic [COUNT_W-1:0]  leave_q;
   logic [VAL_W-1:0]    period_q;
   logic [VAL_W-1:0]    top_q;
   logic [VAL_W-1:0]    cmp_q [3];
   logic [SECTOR_W-1:0] sector_q;
   logic [COUNT_W-1:0]  ticks_q;
   logic [COUNT_W-1:0]  capture_q;
   logic                sine_q;

   function automatic string describe(commutation_type r);
      return $sformatf({"drv=%0d cmp=%0d period=%0d top=%0d u=%0d v=%0d w=%0d",
                        " sector=%0d sine=%0d capt=%0d"},
                       r.drive_update, r.compare_update, r.period, r.top, r.phase_u,
                       r.phase_v, r.phase_w, r.sector, r.sine_mode, r.captured);
   endfunction

   task automatic advance_commutation(input logic [1:0] op, input logic [REQ_W-1:0] data,
                                      output commutation_type res);
      logic [2:0]          code;
      logic [POT_BITS-1:0] pot;
      logic [63:0]         prod;
      int                  half;
      int                  delta;
      int                  plus_k;
      int                  minus_k;
      int                  v;
      res = '0;
      case (op)
         OP_HALL: begin
            code = {data[1], data[2], data[0]};   // u + 2*w + 4*v
            pot  = data[3 +: POT_BITS];
            case (code)
               3'd1:    sector_q = 3'd4;
               3'd2:    sector_q = 3'd2;
               3'd3:    sector_q = 3'd3;
               3'd4:    sector_q = 3'd0;
               3'd5:    sector_q = 3'd5;
               3'd6:    sector_q = 3'd1;
               default: sector_q = SECTOR_INVALID;
            endcase
            // sine mode: sector only
            if (!sine_q) begin
               if (pot < POT_LOW_LIMIT) period_q = PERIOD_SLOW;
               else if (pot < POT_HIGH_LIMIT) period_q = VAL_W'(PERIOD_BASE + pot);
               top_q = VAL_W'(period_q + dead_q);
               res.drive_update = 1'b1;
               if (sector_q != SECTOR_INVALID) begin
                  half  = top_q / 2;
                  prod  = 64'(pot) * 64'(top_q) * 64'(gain_q);
                  delta = int'(prod >> (POT_BITS + 16));
                  // phase pulled above half and phase pulled below half
                  case (sector_q)
                     3'd0:    begin plus_k = 0; minus_k = 1; end
                     3'd1:    begin plus_k = 0; minus_k = 2; end
                     3'd2:    begin plus_k = 1; minus_k = 2; end
                     3'd3:    begin plus_k = 1; minus_k = 0; end
                     3'd4:    begin plus_k = 2; minus_k = 0; end
                     default: begin plus_k = 2; minus_k = 1; end
                  endcase
                  for (int k = 0; k < 3; k++) begin
                     if (k == plus_k) v = (half + delta > top_q) ? int'(top_q) : half + delta;
                     else if (k == minus_k) v = (delta > half) ? 0 : half - delta;
                     else v = half;
                     cmp_q[k] = VAL_W'(v);
                  end
                  res.compare_update = 1'b1;
               end
            end
         end
         OP_TICK: begin
            ticks_q = ticks_q + 1'b1;
            if (ticks_q >= TICK_SIX_STEP) sine_q = 1'b0;
            if (ticks_q >= TICK_WRAP) ticks_q = TICK_SIX_STEP;
         end
         OP_CAPTURE: begin
            capture_q = ticks_q;
            ticks_q   = '0;
            // clear wins when both thresholds hold
            if (capture_q <= enter_q) sine_q = 1'b1;
            if (capture_q >= leave_q) sine_q = 1'b0;
         end
         default: ;
      endcase
      res.period    = period_q;
      res.top       = top_q;
      res.phase_u   = cmp_q[0];
      res.phase_v   = cmp_q[1];
      res.phase_w   = cmp_q[2];
      res.sector    = sector_q;
      res.sine_mode = sine_q;
      res.captured  = capture_q;
   endtask

   always @(posedge clock) begin
      commutation_type want;
      commutation_type seen;
      if (reset) begin
         dead_q    = DEAD_RESET;
         gain_q    = GAIN_RESET;
         enter_q   = ENTER_RESET;
         leave_q   = LEAVE_RESET;
         period_q  = PERIOD_RESET;
         top_q     = '0;
         cmp_q[0]  = '0;
         cmp_q[1]  = '0;
         cmp_q[2]  = '0;
         sector_q  = '0;
         ticks_q   = TICK_RESET;
         capture_q = '0;
         sine_q    = 1'b0;
         pending_commutations.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEAD_TIME:  dead_q  = csr_wdata[DEAD_W-1:0];
               CSR_DRIVE_GAIN: gain_q  = csr_wdata[GAIN_W-1:0];
               CSR_ENTER_SINE: enter_q = csr_wdata[COUNT_W-1:0];
               CSR_LEAVE_SINE: leave_q = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.drive_update   = rsp_tuser[0];
            seen.compare_update = rsp_tuser[1];
            seen.period         = rsp_tdata[0 +: VAL_W];
            seen.top            = rsp_tdata[14 +: VAL_W];
            seen.phase_u        = rsp_tdata[28 +: VAL_W];
            seen.phase_v        = rsp_tdata[42 +: VAL_W];
            seen.phase_w        = rsp_tdata[56 +: VAL_W];
            seen.sector         = rsp_tdata[70 +: SECTOR_W];
            seen.sine_mode      = rsp_tdata[73];
            seen.captured       = rsp_tdata[74 +: COUNT_W];
            if (pending_commutations.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transfer with none expected: %s", $realtime,
                           describe(seen));
            end else begin
               want = pending_commutations.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                              describe(want), describe(seen));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            advance_commutation(req_tuser, req_tdata, want);
            pending_commutations.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending    <= pending_commutations.size();
   end

endmodule

>>> tb/tb_hall_six_step_commutation.sv
// Testbench top for the hall commutation block: clock, reset, stimulus and verdict.
module tb_hall_six_step_commutation;
   timeunit 1ns;
   timeprecision 1ps;
   import hss_pkg::*;

   localparam int POT_BITS       = POT_BITS_DEFAULT;
   localparam int REQ_W          = ((3 + POT_BITS + 7) / 8) * 8;
   localparam int PHASE_ITEMS    = 188;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int END_SETTLE     = 12;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic [1:0]            req_tuser  = OP_NONE;
   logic                  req_tvalid = 1'b0;
   wire logic             req_tready;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;
   wire logic [RSP_USER_W-1:0] rsp_tuser;
   wire logic             rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_DEAD_TIME;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    fail_count;
   int                    pending;
   bit                    quiet      = 1'b0;
   int                    stall_left = 0;
   int                    idle_cycles = 0;

   hall_six_step_commutation #(.POT_BITS(POT_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   hss_commutation_checker #(.POT_BITS(POT_BITS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [POT_BITS-1:0] pick_pot();
      case ($urandom_range(0, 3))
         0:       return POT_BITS'($urandom_range(0, 799));
         1:       return POT_BITS'($urandom_range(800, 2999));
         2:       return POT_BITS'($urandom_range(3000, 4095));
         default: return POT_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] code_of_sector(input int sector);
      case (sector)
         0:       return 3'd4;
         1:       return 3'd6;
         2:       return 3'd2;
         3:       return 3'd3;
         4:       return 3'd1;
         default: return 3'd5;
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] rand_data();
      return REQ_W'($urandom_range(0, 2 ** (3 + POT_BITS) - 1));
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      if (quiet) begin
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_tready = (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called and returns at a falling edge; valid stays high after the transfer
   task automatic send_item(input op_type op, input logic [REQ_W-1:0] data);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = data;
      req_tuser  = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_hall(input logic [2:0] code, input logic [POT_BITS-1:0] pot);
      send_item(OP_HALL, REQ_W'({pot, code[1], code[2], code[0]}));
   endtask

   // hold off until every expected result has arrived
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input int value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic write_config(input int dead, input int gain, input int enter_cnt,
                               input int leave_cnt);
      drain();
      put_reg(CSR_DEAD_TIME, dead);
      put_reg(CSR_DRIVE_GAIN, gain);
      put_reg(CSR_ENTER_SINE, enter_cnt);
      put_reg(CSR_LEAVE_SINE, leave_cnt);
      csr_we = 1'b0;
   endtask

   task automatic run_directed();
      // every hall code, pot at each range boundary
      send_hall(3'd0, 1000);
      send_hall(3'd1, 0);
      send_hall(3'd2, 799);
      send_hall(3'd3, 800);
      send_hall(3'd4, 2999);
      send_hall(3'd5, 3000);
      send_hall(3'd6, 4095);
      send_hall(3'd7, 4095);
      // full gain and dead time: compares saturate at top and zero
      write_config(1023, 65535, ENTER_RESET, LEAVE_RESET);
      for (int s = 0; s < 6; s++) send_hall(code_of_sector(s), 4095);
      send_hall(code_of_sector(0), 0);
      send_item(OP_NONE, rand_data());
      send_item(OP_TICK, rand_data());
      send_item(OP_CAPTURE, rand_data());
      repeat (3) send_item(OP_TICK, rand_data());
      // short count enters sine mode, then hall edges move the sector only
      send_item(OP_CAPTURE, rand_data());
      send_hall(3'd5, 1500);
      send_hall(3'd7, 1500);
      send_item(OP_TICK, rand_data());
   endtask

   task automatic random_traffic(input int n);
      int                  sent;
      int                  pick;
      int                  len;
      int                  dir;
      int                  sector;
      logic [POT_BITS-1:0] pot;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 63) == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_hall(3'($urandom_range(1, 6)), pick_pot());
            sent++;
         end else if (pick < 45) begin
            // rotor turning through consecutive sectors
            len    = $urandom_range(6, 12);
            sector = $urandom_range(0, 5);
            dir    = $urandom_range(0, 1) ? 1 : 5;
            pot    = pick_pot();
            repeat (len) begin
               send_hall(code_of_sector(sector), pot);
               sector = (sector + dir) % 6;
            end
            sent += len;
         end else if (pick < 63) begin
            // speed measurement: ticks closed by a capture
            len = $urandom_range(0, 16);
            repeat (len) send_item(OP_TICK, rand_data());
            send_item(OP_CAPTURE, rand_data());
            sent += len + 1;
         end else if (pick < 64) begin
            // long run to reach the six-step count and the counter wrap
            len = $urandom_range(95, 210);
            repeat (len) send_item(OP_TICK, rand_data());
            sent += len;
         end else if (pick < 72) begin
            send_item(OP_CAPTURE, rand_data());
            sent++;
         end else if (pick < 83) begin
            send_item(OP_TICK, rand_data());
            sent++;
         end else if (pick < 88) begin
            send_item(OP_NONE, rand_data());
         end else if (pick < 90) begin
            drain();
         end else begin
            send_hall($urandom_range(0, 1) ? 3'd7 : 3'd0, pick_pot());
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      random_traffic(PHASE_ITEMS);
      write_config(0, 0, 0, 0);
      random_traffic(PHASE_ITEMS);
      write_config(1023, 65535, 200, 200);
      random_traffic(PHASE_ITEMS);
      write_config(DEAD_RESET, GAIN_RESET, ENTER_RESET, LEAVE_RESET);
      random_traffic(PHASE_ITEMS);
      write_config($urandom_range(0, 1023), $urandom_range(0, 65535),
                   $urandom_range(0, 40), $urandom_range(0, 40));
      random_traffic(PHASE_ITEMS);
      write_config($urandom_range(0, 1023), $urandom_range(0, 65535),
                   $urandom_range(0, 200), $urandom_range(0, 200));
      random_traffic(PHASE_ITEMS);
      drain();
      repeat (END_SETTLE) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
